>>> rtl/core/vnu_pkg.sv
// Package for the vector normalise unit: default widths shared by every module.
// Depends on nothing.
package vnu_pkg;

    // Default component width and number of fraction bits (signed Q16.16).
    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

>>> rtl/core/vnu_square.sv
// Magnitude and sum-of-squares front end of the vector normalise unit.
// Depends on vnu_pkg for its default width.
module vnu_square #(
    parameter int COMP_WIDTH = vnu_pkg::COMP_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COMP_WIDTH-1:0] in_x,
    input  logic signed [COMP_WIDTH-1:0] in_y,
    input  logic signed [COMP_WIDTH-1:0] in_z,
    output logic                         out_valid,
    output logic [2*COMP_WIDTH-1:0]      out_sum,
    output logic [COMP_WIDTH-1:0]        out_mag [0:2],
    output logic [2:0]                   out_neg
);

    localparam int CW = COMP_WIDTH;
    localparam int H  = (CW + 1) / 2;
    localparam int HW = CW - H;
    localparam int SW = 2 * CW;

    logic [CW-1:0]   comp [0:2];
    logic [CW-1:0]   mag1_reg [0:2];
    logic [CW-1:0]   mag2_reg [0:2];
    logic [CW-1:0]   mag3_reg [0:2];
    logic [CW-1:0]   mag4_reg [0:2];
    logic [2:0]      neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [2*H-1:0]  ll_reg [0:2];
    logic [CW-1:0]   lh_reg [0:2];
    logic [2*HW-1:0] hh_reg [0:2];
    logic [SW-1:0]   sq_reg [0:2];
    logic [SW-1:0]   sum_reg;
    logic [3:0]      vld_reg;

    assign comp[0] = in_x;
    assign comp[1] = in_y;
    assign comp[2] = in_z;

    // Valid bits travel alongside the four data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Stage 1 takes magnitudes, stage 2 forms half-width partial products,
    // stage 3 assembles each square and stage 4 adds the three squares.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_reg[i] <= comp[i][CW-1] ? (~comp[i] + CW'(1)) : comp[i];
            neg1_reg[i] <= comp[i][CW-1];
            ll_reg[i]   <= mag1_reg[i][H-1:0] * mag1_reg[i][H-1:0];
            lh_reg[i]   <= CW'(mag1_reg[i][H-1:0] * mag1_reg[i][CW-1:H]);
            hh_reg[i]   <= mag1_reg[i][CW-1:H] * mag1_reg[i][CW-1:H];
            sq_reg[i]   <= (SW'(hh_reg[i]) << (2 * H)) + (SW'(lh_reg[i]) << (H + 1))
                           + SW'(ll_reg[i]);
            mag2_reg[i] <= mag1_reg[i];
            mag3_reg[i] <= mag2_reg[i];
            mag4_reg[i] <= mag3_reg[i];
        end
        neg2_reg <= neg1_reg;
        neg3_reg <= neg2_reg;
        neg4_reg <= neg3_reg;
        sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    assign out_valid = vld_reg[3];
    assign out_sum   = sum_reg;
    assign out_mag   = mag4_reg;
    assign out_neg   = neg4_reg;

endmodule

>>> rtl/core/vnu_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on vnu_pkg for its default width.
module vnu_sqrt #(
    parameter int COMP_WIDTH = vnu_pkg::COMP_WIDTH_DEF,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [2*COMP_WIDTH-1:0] in_sum,
    input  logic [SIDE_WIDTH-1:0]   in_side,
    output logic                    out_valid,
    output logic [COMP_WIDTH-1:0]   out_root,
    output logic [SIDE_WIDTH-1:0]   out_side
);

    localparam int CW = COMP_WIDTH;
    localparam int RW = CW + 3;

    logic [RW-1:0]         rem_reg  [0:CW-1];
    logic [CW-1:0]         root_reg [0:CW-1];
    logic [2*CW-1:0]       rad_reg  [0:CW-1];
    logic [SIDE_WIDTH-1:0] side_reg [0:CW-1];
    logic [CW-1:0]         vld_reg;

    // Each stage brings down two radicand bits and tries the next root bit.
    for (genvar k = 0; k < CW; k++)
    begin : g_stage
        logic [RW-1:0]         rem_prev;
        logic [CW-1:0]         root_prev;
        logic [2*CW-1:0]       rad_prev;
        logic [SIDE_WIDTH-1:0] side_prev;
        logic                  vld_prev;
        logic [RW-1:0]         rem_try;
        logic [RW-1:0]         trial;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_sum;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign rem_try = {rem_prev[RW-3:0], rad_prev[2*CW-1:2*CW-2]};
        assign trial   = RW'({root_prev, 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_try >= trial)
            begin
                rem_reg[k]  <= rem_try - trial;
                root_reg[k] <= {root_prev[CW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= rem_try;
                root_reg[k] <= {root_prev[CW-2:0], 1'b0};
            end
            rad_reg[k]  <= {rad_prev[2*CW-3:0], 2'b00};
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = vld_reg[CW-1];
    assign out_root  = root_reg[CW-1];
    assign out_side  = side_reg[CW-1];

endmodule

>>> rtl/core/vnu_div.sv
// Pipelined fraction divider: three lanes of magnitude / length, one
// quotient bit per stage. Depends on vnu_pkg for its default widths.
module vnu_div #(
    parameter int COMP_WIDTH = vnu_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = vnu_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [COMP_WIDTH-1:0] in_len,
    input  logic [COMP_WIDTH-1:0] in_mag [0:2],
    input  logic [2:0]            in_neg,
    output logic                  out_valid,
    output logic [FRAC_BITS:0]    out_quot [0:2],
    output logic [2:0]            out_neg,
    output logic [COMP_WIDTH-1:0] out_len,
    output logic                  out_zero
);

    localparam int CW = COMP_WIDTH;
    localparam int NS = FRAC_BITS + 1;

    logic [CW-1:0]    rem_reg  [0:NS-1][0:2];
    logic [FRAC_BITS:0] quot_reg [0:NS-1][0:2];
    logic [CW-1:0]    len_reg  [0:NS-1];
    logic [2:0]       neg_reg  [0:NS-1];
    logic [NS-1:0]    zero_reg;
    logic [NS-1:0]    vld_reg;

    // The first stage compares the magnitude itself; later ones shift first.
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [CW:0]        rem_try [0:2];
        logic [FRAC_BITS:0] quot_prev [0:2];
        logic [CW-1:0]      len_prev;
        logic [2:0]         neg_prev;
        logic               zero_prev;
        logic               vld_prev;

        if (k == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_try[i]   = {1'b0, in_mag[i]};
                assign quot_prev[i] = '0;
            end
            assign len_prev  = in_len;
            assign neg_prev  = in_neg;
            assign zero_prev = (in_len == '0);
            assign vld_prev  = in_valid;
        end
        else
        begin : g_next
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_try[i]   = {rem_reg[k-1][i], 1'b0};
                assign quot_prev[i] = quot_reg[k-1][i];
            end
            assign len_prev  = len_reg[k-1];
            assign neg_prev  = neg_reg[k-1];
            assign zero_prev = zero_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_try[i] >= {1'b0, len_prev})
                begin
                    rem_reg[k][i]  <= CW'(rem_try[i] - {1'b0, len_prev});
                    quot_reg[k][i] <= {quot_prev[i][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[k][i]  <= rem_try[i][CW-1:0];
                    quot_reg[k][i] <= {quot_prev[i][FRAC_BITS-1:0], 1'b0};
                end
            end
            len_reg[k]  <= len_prev;
            neg_reg[k]  <= neg_prev;
            zero_reg[k] <= zero_prev;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_quot  = quot_reg[NS-1];
    assign out_neg   = neg_reg[NS-1];
    assign out_len   = len_reg[NS-1];
    assign out_zero  = zero_reg[NS-1];

endmodule

>>> rtl/core/vector3_normalize_unit.sv
// Top level of the vector normalise unit: length and unit vector of one vector.
// Depends on vnu_pkg, vnu_square, vnu_sqrt and vnu_div.
//
//   Channel   Handshake        Word
//   input     start / busy     in_x, in_y, in_z
//   result    done (strobe)    unit_x, unit_y, unit_z, vec_length, zero_flag
//
// A word is taken in every cycle that start is high; busy stays low.
// A result passes the square front end, the square root pipeline (one root bit a
// stage), the divider (one quotient bit a stage) and the result register. done
// marks each result for exactly one cycle, in input order.
// Reset clears only the valid bits of the pipeline.
module vector3_normalize_unit #(
    parameter int COMP_WIDTH = vnu_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = vnu_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COMP_WIDTH-1:0] in_x,
    input  logic signed [COMP_WIDTH-1:0] in_y,
    input  logic signed [COMP_WIDTH-1:0] in_z,
    output logic                         done,
    output logic signed [COMP_WIDTH-1:0] unit_x,
    output logic signed [COMP_WIDTH-1:0] unit_y,
    output logic signed [COMP_WIDTH-1:0] unit_z,
    output logic [COMP_WIDTH-1:0]        vec_length,
    output logic                         zero_flag
);

    localparam int CW    = COMP_WIDTH;
    localparam int SIDEW = 3 * CW + 3;
    localparam int UW    = (FRAC_BITS + 1 > CW) ? FRAC_BITS + 1 : CW;

    logic               sq_valid;
    logic [2*CW-1:0]    sq_sum;
    logic [CW-1:0]      sq_mag [0:2];
    logic [2:0]         sq_neg;
    logic               rt_valid;
    logic [CW-1:0]      rt_root;
    logic [SIDEW-1:0]   rt_side;
    logic [CW-1:0]      rt_mag [0:2];
    logic               dv_valid;
    logic [FRAC_BITS:0] dv_quot [0:2];
    logic [2:0]         dv_neg;
    logic [CW-1:0]      dv_len;
    logic               dv_zero;
    logic [UW-1:0]      quot_ext [0:2];
    logic [UW-1:0]      unit_next [0:2];
    logic [CW-1:0]      unit_reg [0:2];
    logic [CW-1:0]      len_reg;
    logic               zero_reg;
    logic               done_reg;

    // The pipeline never stalls, so a word is taken every cycle.
    assign busy = 1'b0;

    vnu_square #(
        .COMP_WIDTH (CW)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (sq_valid),
        .out_sum   (sq_sum),
        .out_mag   (sq_mag),
        .out_neg   (sq_neg)
    );

    vnu_sqrt #(
        .COMP_WIDTH (CW),
        .SIDE_WIDTH (SIDEW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_sum    (sq_sum),
        .in_side   ({sq_neg, sq_mag[0], sq_mag[1], sq_mag[2]}),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    assign rt_mag[0] = rt_side[3*CW-1:2*CW];
    assign rt_mag[1] = rt_side[2*CW-1:CW];
    assign rt_mag[2] = rt_side[CW-1:0];

    vnu_div #(
        .COMP_WIDTH (CW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_len    (rt_root),
        .in_mag    (rt_mag),
        .in_neg    (rt_side[SIDEW-1:3*CW]),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_neg   (dv_neg),
        .out_len   (dv_len),
        .out_zero  (dv_zero)
    );

    // Restore the sign; a zero length gives the zero input back, which is zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot_ext[i] = UW'(dv_quot[i]);
            if (dv_zero)
            begin
                unit_next[i] = '0;
            end
            else if (dv_neg[i])
            begin
                unit_next[i] = ~quot_ext[i] + UW'(1);
            end
            else
            begin
                unit_next[i] = quot_ext[i];
            end
        end
    end

    // Result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            unit_reg[i] <= unit_next[i][CW-1:0];
        end
        len_reg  <= dv_len;
        zero_reg <= dv_zero;
    end

    assign done       = done_reg;
    assign unit_x     = unit_reg[0];
    assign unit_y     = unit_reg[1];
    assign unit_z     = unit_reg[2];
    assign vec_length = len_reg;
    assign zero_flag  = zero_reg;

endmodule
